@@ src/first_fit_heap_allocator_assert.svh @@
// Assertion macros of the heap allocator checker.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FFA_ASSERT_IMPL(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FFA_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

@@ src/ffa_pkg.sv @@
// Types and constants of the first-fit heap allocator.
package ffa_pkg;

	localparam int unsigned UNIT_BYTES = 8;
	localparam int unsigned OFF_W      = 12;
	localparam int unsigned STATUS_W   = 3;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_PTR   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_DOUBLE    = 3'd5;

	typedef struct packed {
		logic        func;
		logic [15:0] req_bytes;
		logic [15:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [OFF_W-1:0]    payload_offset;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_SPLIT,
		WR_ALLOC,
		WR_TGT,
		WR_PREV
	} wr_kind_t;

	typedef struct packed {
		logic                start;
		logic                rd;
		logic                step;
		logic                take;
		logic                merge;
		wr_kind_t            wr;
		logic                load_out;
		logic [STATUS_W-1:0] status;
	} cmd_t;

	typedef struct packed {
		logic req_zero;
		logic req_big;
		logic off_bad;
		logic cur_zero;
		logic cur_used;
		logic cur_fits;
		logic cur_split;
		logic next_end;
		logic pos_lt_tgt;
		logic pos_eq_tgt;
		logic prev_free;
	} sts_t;

endpackage

@@ src/ffa_if.sv @@
// Request and response stream interfaces of the heap allocator.
interface ffa_req_if;
	logic          valid;
	logic          ready;
	ffa_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffa_rsp_if;
	logic          valid;
	logic          ready;
	ffa_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: request and response channels around controller and datapath.
//
// Requests arrive on req (func, req_bytes, free_offset) and each one yields exactly
// one response on rsp (payload_offset, status). func 0 allocates req_bytes rounded up
// to 8-byte units plus a header unit; func 1 frees the payload at free_offset and
// merges the block with free neighbors.
// One request is in work at a time. A request rejected on its fields goes to its
// response without a walk. An allocate or a free reads block headers (the successor
// of a freed block included; at most HEAP_UNITS) and writes 0 to 2 headers.
// The walk reads one header per cycle from the single header memory.
// The response sits in an output register; req.ready rises again as soon as it is
// loaded, so the next request is taken while the response waits. If rsp is stalled
// when the next result is done, the block holds that result until the register frees.
// Reset leaves the heap as one free block spanning all HEAP_UNITS units, ready to
// accept, with no response pending; no clearing pass is needed.
module first_fit_heap_allocator #(
	parameter int unsigned HEAP_UNITS = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	ffa_req_if.sink      req,
	ffa_rsp_if.source    rsp
);
	import ffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_func   (req.payload.func),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_dp #(
		.HEAP_UNITS (HEAP_UNITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.payload),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_data (rsp.payload)
	);

endmodule

@@ src/ffa_ctrl.sv @@
// Controller state machine of the heap allocator: walk, write and result sequencing.
module ffa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_func,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  ffa_pkg::sts_t  sts,
	output ffa_pkg::cmd_t  cmd
);
	import ffa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE,
		S_SUCC,
		S_SPLIT,
		S_GRANT,
		S_WR_TGT,
		S_WR_PREV,
		S_FINISH
	} state_t;

	state_t              state_q, state_d;
	logic                in_ready_q, in_ready_d;
	logic                out_valid_q, out_valid_d;
	logic [STATUS_W-1:0] status_q, status_d;

	always_comb begin
		cmd         = '0;
		cmd.wr      = WR_NONE;
		cmd.status  = status_q;
		state_d     = state_q;
		status_d    = status_q;
		in_ready_d  = in_ready_q;
		out_valid_d = out_valid_q & ~out_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.start  = 1'b1;
					in_ready_d = 1'b0;
					if (in_func == FUNC_FREE) begin
						if (sts.off_bad) begin
							status_d = ST_BAD_PTR;
							state_d  = S_FINISH;
						end else begin
							cmd.rd  = 1'b1;
							state_d = S_FREE;
						end
					end else if (sts.req_zero) begin
						status_d = ST_ZERO;
						state_d  = S_FINISH;
					end else if (sts.req_big) begin
						status_d = ST_TOO_LARGE;
						state_d  = S_FINISH;
					end else begin
						cmd.rd  = 1'b1;
						state_d = S_ALLOC;
					end
				end
			end
			S_ALLOC: begin
				if (sts.cur_zero) begin
					status_d = ST_NO_FIT;
					state_d  = S_FINISH;
				end else if (!sts.cur_used && sts.cur_fits) begin
					state_d = sts.cur_split ? S_SPLIT : S_GRANT;
				end else if (sts.next_end) begin
					status_d = ST_NO_FIT;
					state_d  = S_FINISH;
				end else begin
					cmd.step = 1'b1;
					cmd.rd   = 1'b1;
				end
			end
			S_FREE: begin
				if (sts.pos_lt_tgt) begin
					if (sts.cur_zero || sts.next_end) begin
						status_d = ST_BAD_PTR;
						state_d  = S_FINISH;
					end else begin
						cmd.step = 1'b1;
						cmd.rd   = 1'b1;
					end
				end else if (!sts.pos_eq_tgt || sts.cur_zero) begin
					status_d = ST_BAD_PTR;
					state_d  = S_FINISH;
				end else if (!sts.cur_used) begin
					status_d = ST_DOUBLE;
					state_d  = S_FINISH;
				end else begin
					cmd.take = 1'b1;
					if (sts.next_end) begin
						state_d = S_WR_TGT;
					end else begin
						cmd.rd  = 1'b1;
						state_d = S_SUCC;
					end
				end
			end
			S_SUCC: begin
				cmd.merge = ~sts.cur_used;
				state_d   = S_WR_TGT;
			end
			S_SPLIT: begin
				cmd.wr  = WR_SPLIT;
				state_d = S_GRANT;
			end
			S_GRANT: begin
				cmd.wr   = WR_ALLOC;
				status_d = ST_OK;
				state_d  = S_FINISH;
			end
			S_WR_TGT: begin
				cmd.wr = WR_TGT;
				if (sts.prev_free) begin
					state_d = S_WR_PREV;
				end else begin
					status_d = ST_OK;
					state_d  = S_FINISH;
				end
			end
			S_WR_PREV: begin
				cmd.wr   = WR_PREV;
				status_d = ST_OK;
				state_d  = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					out_valid_d  = 1'b1;
					in_ready_d   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
		end else begin
			state_q     <= state_d;
			in_ready_q  <= in_ready_d;
			out_valid_q <= out_valid_d;
			status_q    <= status_d;
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

@@ src/ffa_dp.sv @@
// Datapath of the heap allocator: header memory, walk position, lengths and result register.
module ffa_dp #(
	parameter int unsigned HEAP_UNITS = 512
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ffa_pkg::req_t req_data,
	input  ffa_pkg::cmd_t cmd,
	output ffa_pkg::sts_t sts,
	output ffa_pkg::rsp_t rsp_data
);
	import ffa_pkg::*;

	localparam int unsigned AW = $clog2(HEAP_UNITS);
	localparam int unsigned PW = AW + 1;
	localparam int unsigned HW = PW + 1;
	localparam logic [PW-1:0] HEAP_LEN = PW'(HEAP_UNITS);
	localparam logic [16:0]   BYTE_LIM = 17'(HEAP_UNITS * UNIT_BYTES);
	localparam logic [12:0]   UNIT_LIM = 13'(HEAP_UNITS);

	logic [HW-1:0] mem [HEAP_UNITS];
	logic [HW-1:0] rd_data_q;
	logic          rd_zero_q;
	logic          hdr0_valid_q;

	logic [PW-1:0] pos_q, need_q, tgt_q, prev_q, prev_len_q, tlen_q;
	logic          prev_used_q, have_prev_q;
	logic [OFF_W-1:0] off_q;
	rsp_t          rsp_q;

	logic [16:0]   units_sum;
	logic [PW-1:0] need_in;
	logic [12:0]   off_units, tgt_full;
	logic [HW-1:0] hdr;
	logic [PW-1:0] raw_len, room, cur_len, next_pos;
	logic          cur_used;
	logic [PW+2:0] grant_off;
	logic          we;
	logic [PW-1:0] wa_full;
	logic [HW-1:0] wd;
	logic [AW-1:0] ra;

	assign units_sum = ({1'b0, req_data.req_bytes} + 17'd7) >> 3;
	assign need_in   = PW'(units_sum) + PW'(1);
	assign off_units = req_data.free_offset[15:3];
	assign tgt_full  = off_units - 13'd1;

	assign hdr      = rd_zero_q ? {1'b0, HEAP_LEN} : rd_data_q;
	assign raw_len  = hdr[PW-1:0];
	assign cur_used = hdr[PW];
	assign room     = HEAP_LEN - pos_q;
	assign cur_len  = (raw_len > room) ? room : raw_len;
	assign next_pos = pos_q + cur_len;
	assign grant_off = {pos_q + PW'(1), 3'b000};

	always_comb begin
		sts.req_zero   = (req_data.req_bytes == 16'd0);
		sts.req_big    = ({1'b0, req_data.req_bytes} > BYTE_LIM);
		sts.off_bad    = (off_units == 13'd0) || (req_data.free_offset[2:0] != 3'd0) ||
			(tgt_full >= UNIT_LIM);
		sts.cur_zero   = (cur_len == '0);
		sts.cur_used   = cur_used;
		sts.cur_fits   = (cur_len >= need_q);
		sts.cur_split  = (cur_len > need_q);
		sts.next_end   = (next_pos >= HEAP_LEN);
		sts.pos_lt_tgt = (pos_q < tgt_q);
		sts.pos_eq_tgt = (pos_q == tgt_q);
		sts.prev_free  = have_prev_q & ~prev_used_q;
	end

	always_comb begin
		we      = 1'b1;
		wa_full = pos_q;
		wd      = '0;
		case (cmd.wr)
			WR_SPLIT: begin
				wa_full = pos_q + need_q;
				wd      = {1'b0, cur_len - need_q};
			end
			WR_ALLOC: begin
				wa_full = pos_q;
				wd      = {1'b1, need_q};
			end
			WR_TGT: begin
				wa_full = tgt_q;
				wd      = {1'b0, tlen_q};
			end
			WR_PREV: begin
				wa_full = prev_q;
				wd      = {1'b0, prev_len_q + tlen_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	assign ra = cmd.start ? '0 : next_pos[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa_full[AW-1:0]] <= wd;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr0_valid_q <= 1'b0;
			rd_zero_q    <= 1'b0;
		end else begin
			if (we && (wa_full == '0)) begin
				hdr0_valid_q <= 1'b1;
			end
			if (cmd.rd) begin
				rd_zero_q <= (ra == '0) && !hdr0_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pos_q       <= '0;
			need_q      <= need_in;
			tgt_q       <= PW'(tgt_full);
			have_prev_q <= 1'b0;
			off_q       <= '0;
		end
		if (cmd.step) begin
			prev_q      <= pos_q;
			prev_len_q  <= cur_len;
			prev_used_q <= cur_used;
			have_prev_q <= 1'b1;
			pos_q       <= next_pos;
		end
		if (cmd.take) begin
			tlen_q <= cur_len;
			pos_q  <= next_pos;
		end
		if (cmd.merge) begin
			tlen_q <= tlen_q + cur_len;
		end
		if (cmd.wr == WR_ALLOC) begin
			off_q <= OFF_W'(grant_off);
		end
		if (cmd.load_out) begin
			rsp_q.payload_offset <= off_q;
			rsp_q.status         <= cmd.status;
		end
	end

	assign rsp_data = rsp_q;

endmodule

@@ src/ffa_checker.sv @@
// Port-level checker of the heap allocator and its bind to the top level.
`include "first_fit_heap_allocator_assert.svh"

module ffa_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input ffa_pkg::rsp_t rsp_data
);
	import ffa_pkg::*;

	`FFA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")
	`FFA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")
	`FFA_ASSERT_IMPL(a_err_zero_off, rsp_valid && (rsp_data.status != ST_OK), rsp_data.payload_offset == '0, "offset nonzero on error")
	`FFA_ASSERT_IMPL(a_off_aligned, rsp_valid, rsp_data.payload_offset[2:0] == 3'd0, "offset not unit aligned")

endmodule

bind first_fit_heap_allocator ffa_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.payload)
);

@@ tb/testbench.sv @@
// Self-checking testbench of the first-fit heap allocator: directed table, then random requests.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ffa_pkg::*;

	localparam int unsigned HEAP_UNITS   = 512;
	localparam int unsigned HEAP_BYTES   = HEAP_UNITS * UNIT_BYTES;
	localparam logic [15:0] USED_BIT     = 16'h8000;
	localparam logic [15:0] LEN_BITS     = 16'h1FFF;
	localparam int unsigned RANDOM_REQS  = 1124;
	localparam int unsigned IDLE_LIMIT   = 4000;
	localparam int unsigned DRAIN_CYCLES = 600;

	typedef struct packed {
		logic                func;
		logic [15:0]         req_bytes;
		logic [15:0]         free_offset;
		logic                typed;
		logic [OFF_W-1:0]    exp_offset;
		logic [STATUS_W-1:0] exp_status;
	} probe_t;

	localparam probe_t PROBES [26] = '{
		'{FUNC_ALLOC, 16'd0,    16'd0,    1'b1, 12'd0,  ST_ZERO},
		'{FUNC_ALLOC, 16'd4097, 16'd0,    1'b1, 12'd0,  ST_TOO_LARGE},
		'{FUNC_ALLOC, 16'hFFFF, 16'd0,    1'b1, 12'd0,  ST_TOO_LARGE},
		'{FUNC_ALLOC, 16'd4096, 16'd0,    1'b1, 12'd0,  ST_NO_FIT},
		'{FUNC_FREE,  16'd0,    16'd0,    1'b1, 12'd0,  ST_BAD_PTR},
		'{FUNC_FREE,  16'd0,    16'd12,   1'b1, 12'd0,  ST_BAD_PTR},
		'{FUNC_FREE,  16'd0,    16'hFFF8, 1'b1, 12'd0,  ST_BAD_PTR},
		'{FUNC_FREE,  16'd0,    16'd8,    1'b1, 12'd0,  ST_DOUBLE},
		'{FUNC_ALLOC, 16'd1,    16'd0,    1'b1, 12'd8,  ST_OK},
		'{FUNC_ALLOC, 16'd8,    16'd0,    1'b1, 12'd24, ST_OK},
		'{FUNC_ALLOC, 16'd16,   16'd0,    1'b1, 12'd40, ST_OK},
		'{FUNC_FREE,  16'd0,    16'd16,   1'b1, 12'd0,  ST_BAD_PTR},
		'{FUNC_FREE,  16'd0,    16'd24,   1'b0, 12'd0,  ST_OK},
		'{FUNC_FREE,  16'd0,    16'd24,   1'b1, 12'd0,  ST_DOUBLE},
		'{FUNC_FREE,  16'd0,    16'd8,    1'b0, 12'd0,  ST_OK},
		'{FUNC_ALLOC, 16'd4072, 16'd0,    1'b0, 12'd0,  ST_OK},
		'{FUNC_FREE,  16'd0,    16'd40,   1'b0, 12'd0,  ST_OK},
		'{FUNC_ALLOC, 16'd4088, 16'd0,    1'b1, 12'd8,  ST_OK},
		'{FUNC_ALLOC, 16'd1,    16'd0,    1'b1, 12'd0,  ST_NO_FIT},
		'{FUNC_FREE,  16'd0,    16'd8,    1'b1, 12'd0,  ST_OK},
		'{FUNC_FREE,  16'hFFFF, 16'hFFFF, 1'b1, 12'd0,  ST_BAD_PTR},
		'{FUNC_ALLOC, 16'd8,    16'd0,    1'b0, 12'd0,  ST_OK},
		'{FUNC_ALLOC, 16'd8,    16'd0,    1'b0, 12'd0,  ST_OK},
		'{FUNC_ALLOC, 16'd8,    16'd0,    1'b0, 12'd0,  ST_OK},
		'{FUNC_FREE,  16'd0,    16'd8,    1'b0, 12'd0,  ST_OK},
		'{FUNC_FREE,  16'd0,    16'd24,   1'b0, 12'd0,  ST_OK}
	};

	logic clk;
	logic arst_n;

	ffa_req_if req_ch ();
	ffa_rsp_if rsp_ch ();

	first_fit_heap_allocator #(
		.HEAP_UNITS(HEAP_UNITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [15:0] heap_hdr [HEAP_UNITS];
	rsp_t        owed_outcomes [$];
	int unsigned live_offsets [$];
	int unsigned freed_offsets [$];
	int unsigned status_seen [8];
	int unsigned errors;
	int unsigned requests_sent;
	int unsigned responses_checked;
	int unsigned quiet_cycles;
	bit          calm;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned span_at(int unsigned pos);
		int unsigned len;
		len = heap_hdr[pos] & LEN_BITS;
		if (len > HEAP_UNITS - pos) begin
			len = HEAP_UNITS - pos;
		end
		return len;
	endfunction

	function automatic bit taken_at(int unsigned pos);
		return (heap_hdr[pos] & USED_BIT) != 16'h0;
	endfunction

	function automatic void mark_block(int unsigned pos, int unsigned len, bit used);
		heap_hdr[pos] = (16'(len) & LEN_BITS) | (used ? USED_BIT : 16'h0);
	endfunction

	function automatic rsp_t first_fit_predict(req_t r);
		rsp_t        o;
		int unsigned need;
		int unsigned pos;
		int unsigned prev;
		int unsigned len;
		int unsigned tgt;
		bit          have_prev;
		o.payload_offset = '0;
		o.status = ST_OK;
		pos = 0;
		prev = 0;
		have_prev = 1'b0;
		if (r.func == FUNC_ALLOC) begin
			if (r.req_bytes == 16'd0) begin
				o.status = ST_ZERO;
				return o;
			end
			if (r.req_bytes > HEAP_BYTES) begin
				o.status = ST_TOO_LARGE;
				return o;
			end
			need = (r.req_bytes + UNIT_BYTES - 1) / UNIT_BYTES + 1;
			while (pos < HEAP_UNITS) begin
				len = span_at(pos);
				if (len == 0) begin
					break;
				end
				if (!taken_at(pos) && len >= need) begin
					if (len > need) begin
						mark_block(pos + need, len - need, 1'b0);
					end
					mark_block(pos, need, 1'b1);
					o.payload_offset = OFF_W'((pos + 1) * UNIT_BYTES);
					return o;
				end
				pos += len;
			end
			o.status = ST_NO_FIT;
			return o;
		end
		o.status = ST_BAD_PTR;
		if (r.free_offset < UNIT_BYTES || (r.free_offset % UNIT_BYTES) != 0) begin
			return o;
		end
		tgt = r.free_offset / UNIT_BYTES - 1;
		if (tgt >= HEAP_UNITS) begin
			return o;
		end
		while (pos < tgt) begin
			len = span_at(pos);
			if (len == 0) begin
				return o;
			end
			prev = pos;
			have_prev = 1'b1;
			pos += len;
		end
		if (pos != tgt) begin
			return o;
		end
		len = span_at(pos);
		if (len == 0) begin
			return o;
		end
		if (!taken_at(pos)) begin
			o.status = ST_DOUBLE;
			return o;
		end
		if (pos + len < HEAP_UNITS && !taken_at(pos + len)) begin
			len += span_at(pos + len);
		end
		mark_block(pos, len, 1'b0);
		if (have_prev && !taken_at(prev)) begin
			mark_block(prev, span_at(prev) + len, 1'b0);
		end
		o.status = ST_OK;
		return o;
	endfunction

	task automatic flag_mismatch(string line);
		errors++;
		$display("%0t ns: %s", $realtime, line);
	endtask

	// Drop the request, then hold until every owed response has come.
	task automatic wait_all_answered();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (owed_outcomes.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Drive one request, then predict its outcome on the transfer edge.
	task automatic issue_request(req_t r, bit typed, rsp_t typed_rsp);
		int unsigned gap;
		rsp_t        predicted;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.payload = r;
		do @(posedge clk); while (!req_ch.ready);
		predicted = first_fit_predict(r);
		owed_outcomes.push_back(typed ? typed_rsp : predicted);
		status_seen[predicted.status]++;
		requests_sent++;
		if (predicted.status == ST_OK) begin
			if (r.func == FUNC_ALLOC) begin
				live_offsets.push_back(predicted.payload_offset);
			end else begin
				for (int i = 0; i < live_offsets.size(); i++) begin
					if (live_offsets[i] == r.free_offset) begin
						live_offsets.delete(i);
						break;
					end
				end
				freed_offsets.push_back(r.free_offset);
				if (freed_offsets.size() > 16) begin
					void'(freed_offsets.pop_front());
				end
			end
		end
	endtask

	initial begin
		req_t        r;
		int unsigned pick;
		int unsigned bucket;
		int unsigned alloc_share;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		calm = 1'b0;
		foreach (heap_hdr[i]) begin
			heap_hdr[i] = 16'h0;
		end
		mark_block(0, HEAP_UNITS, 1'b0);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (PROBES[i]) begin
			r = {PROBES[i].func, PROBES[i].req_bytes, PROBES[i].free_offset};
			issue_request(r, PROBES[i].typed, {PROBES[i].exp_offset, PROBES[i].exp_status});
		end
		wait_all_answered();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n == RANDOM_REQS / 2) begin
				wait_all_answered();
			end
			if ($urandom_range(0, 99) == 0) begin
				calm = !calm;
			end
			r.req_bytes = 16'($urandom);
			r.free_offset = 16'($urandom);
			alloc_share = live_offsets.size() > 48 ? 25 : (live_offsets.size() < 4 ? 75 : 50);
			pick = $urandom_range(0, 99);
			bucket = $urandom_range(0, 99);
			if (pick < alloc_share) begin
				r.func = FUNC_ALLOC;
				if (bucket < 65) begin
					r.req_bytes = 16'($urandom_range(1, 64));
				end else if (bucket < 88) begin
					r.req_bytes = 16'($urandom_range(65, 512));
				end else if (bucket < 96) begin
					r.req_bytes = 16'($urandom_range(513, HEAP_BYTES));
				end else if (bucket < 98) begin
					r.req_bytes = 16'd0;
				end
			end else begin
				r.func = FUNC_FREE;
				if (bucket < 80 && live_offsets.size() > 0) begin
					r.free_offset = 16'(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
				end else if (bucket < 90 && freed_offsets.size() > 0) begin
					r.free_offset = 16'(freed_offsets[$urandom_range(0, freed_offsets.size() - 1)]);
				end else if (bucket < 95) begin
					r.free_offset = 16'($urandom_range(0, HEAP_BYTES + 16));
				end
			end
			issue_request(r, 1'b0, '0);
		end
		@(negedge clk);
		req_ch.valid = 1'b0;

		wait_all_answered();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests: %0d ok, %0d zero size, %0d too large, %0d no fit,",
			requests_sent, status_seen[ST_OK], status_seen[ST_ZERO],
			status_seen[ST_TOO_LARGE], status_seen[ST_NO_FIT]);
		$display("%0d bad pointer, %0d double free; %0d responses checked, %0d mismatches.",
			status_seen[ST_BAD_PTR], status_seen[ST_DOUBLE], responses_checked, errors);
		if (errors == 0) begin
			$display("PASS first_fit_heap_allocator");
		end else begin
			$display("FAIL first_fit_heap_allocator");
		end
		$finish;
	end

	initial begin
		int unsigned stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				@(negedge clk);
				rsp_ch.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (owed_outcomes.size() == 0) begin
				flag_mismatch($sformatf("response with nothing outstanding: offset %0d status %0d",
					rsp_ch.payload.payload_offset, rsp_ch.payload.status));
			end else begin
				want = owed_outcomes.pop_front();
				responses_checked++;
				if (rsp_ch.payload.payload_offset !== want.payload_offset) begin
					flag_mismatch($sformatf("response %0d payload_offset: got %0d, want %0d",
						responses_checked, rsp_ch.payload.payload_offset,
						want.payload_offset));
				end
				if (rsp_ch.payload.status !== want.status) begin
					flag_mismatch($sformatf("response %0d status: got %0d, want %0d",
						responses_checked, rsp_ch.payload.status, want.status));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("No transfer for %0d cycles, %0d responses outstanding.",
				IDLE_LIMIT, owed_outcomes.size());
			$display("FAIL first_fit_heap_allocator");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
